@@ hw/rtl/scm_pkg.sv @@
// ----------------------------------------------------------------------------
// Swept circle first contact: shared package
// Field widths, register indexes, item types and sequencer states.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int INDEX_BITS_DEF = 16;

  localparam int POS_W      = 26;
  localparam int RAD_W      = 19;
  localparam int IDX_W      = 16;
  localparam int DIST_W     = 24;
  localparam int DIR_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DIFF_W = POS_W + 1;
  localparam int RSUM_W = RAD_W + 1;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int H_W    = 31;
  localparam int SQ_W   = 62;
  localparam int ROOT_W = 31;
  localparam int T_W    = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_COS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_SIN     = 2'd2;

  localparam logic [DIST_W-1:0]       STEP_RESET = 24'd65536;
  localparam logic signed [DIR_W-1:0] COS_RESET  = 18'sd65536;
  localparam logic signed [DIR_W-1:0] SIN_RESET  = 18'sd0;

  typedef struct packed {
    logic [POS_W-1:0] mover_x;
    logic [POS_W-1:0] mover_y;
    logic [RAD_W-1:0] mover_radius;
    logic [POS_W-1:0] target_x;
    logic [POS_W-1:0] target_y;
    logic [RAD_W-1:0] target_radius;
    logic [IDX_W-1:0] target_index;
    logic             first_pair;
    logic             last_pair;
  } pair_t;

  typedef struct packed {
    logic [DIST_W-1:0] hit_distance;
    logic [IDX_W-1:0]  hit_target;
    logic              hit_found;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_COS,
    S_MUL_SIN,
    S_MUL_DXX,
    S_MUL_DYY,
    S_MUL_RS,
    S_MUL_HH,
    S_DISC,
    S_SQRT_START,
    S_SQRT_WAIT,
    S_EVAL,
    S_EMIT
  } state_t;

endpackage

@@ hw/rtl/scm_isqrt.sv @@
// ----------------------------------------------------------------------------
// Swept circle first contact: integer square root
// Floor square root of a 62-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module scm_isqrt
  import scm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int                    Steps   = SQ_W / 2;
  localparam int                    CntW    = $clog2(Steps);
  localparam logic [CntW-1:0]       LastCnt = CntW'(Steps - 1);
  localparam logic [SQ_W-1:0]       TopBit  = {2'b01, {(SQ_W-2){1'b0}}};

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] acc_root;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  assign trial = acc_root + bitv;
  assign root  = acc_root[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastCnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= radicand;
      acc_root <= '0;
      bitv     <= TopBit;
    end else if (busy) begin
      if (rem >= trial) begin
        rem      <= rem - trial;
        acc_root <= (acc_root >> 1) + bitv;
      end else begin
        acc_root <= acc_root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

@@ hw/rtl/swept_circle_first_contact_unit.sv @@
// ----------------------------------------------------------------------------
// Swept circle first contact unit
// Free travel distance of a moving circle against a stream of still circles,
// using one shared 32x32 multiplier and a bit-serial square root.
// Steps per pair: the multiply and sum states, the square root, an evaluate
// state and, after a last pair only, an emit state. Without a positive
// discriminant the root is skipped.
// Throughput: one pair at a time, the next taken once the sequencer is idle
// again, later after a last pair and while a result waits.
// Reset: sequencer idle, no result pending, registers at reset values,
// running minimum, target and hit flag cleared to zero.
// ----------------------------------------------------------------------------
module swept_circle_first_contact_unit
  import scm_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pair_valid,
  output logic                  pair_stall,
  input  pair_t                 pair,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int                        KeepBits  = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam logic [IDX_W-1:0]          IdxMask   = {IDX_W{1'b1}} >> (IDX_W - KeepBits);
  localparam logic signed [PROD_W-1:0]  RoundHalf = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0]  HLimit    = 64'sd1073741823;

  state_t state, state_next;

  logic [DIST_W-1:0]       step_length;
  logic signed [DIR_W-1:0] dir_cos;
  logic signed [DIR_W-1:0] dir_sin;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [RSUM_W-1:0]        rs;
  logic [IDX_W-1:0]         idx;
  logic                     last_flag;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] h_wide;
  logic signed [H_W-1:0]    h;
  logic signed [H_W-1:0]    h_sat;

  logic                     sq_start;
  logic                     sq_done;
  logic [ROOT_W-1:0]        sq_root;
  logic                     root_ok;

  logic signed [T_W-1:0]    t;
  logic                     hit;

  logic [DIST_W-1:0]        best_distance;
  logic [IDX_W-1:0]         best_target;
  logic                     any_hit;

  logic                     accept;
  logic                     emit_load;

  assign accept     = pair_valid && !pair_stall;
  assign pair_stall = (state != S_IDLE);

  scm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc[SQ_W-1:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_COS: begin
        mul_a = {{(MUL_W-DIR_W){dir_cos[DIR_W-1]}}, dir_cos};
        mul_b = {{(MUL_W-DIFF_W){dx[DIFF_W-1]}}, dx};
      end
      S_MUL_SIN: begin
        mul_a = {{(MUL_W-DIR_W){dir_sin[DIR_W-1]}}, dir_sin};
        mul_b = {{(MUL_W-DIFF_W){dy[DIFF_W-1]}}, dy};
      end
      S_MUL_DXX: begin
        mul_a = {{(MUL_W-DIFF_W){dx[DIFF_W-1]}}, dx};
        mul_b = {{(MUL_W-DIFF_W){dx[DIFF_W-1]}}, dx};
      end
      S_MUL_DYY: begin
        mul_a = {{(MUL_W-DIFF_W){dy[DIFF_W-1]}}, dy};
        mul_b = {{(MUL_W-DIFF_W){dy[DIFF_W-1]}}, dy};
      end
      S_MUL_RS: begin
        mul_a = {{(MUL_W-RSUM_W){1'b0}}, rs};
        mul_b = {{(MUL_W-RSUM_W){1'b0}}, rs};
      end
      S_MUL_HH: begin
        mul_a = {{(MUL_W-H_W){h[H_W-1]}}, h};
        mul_b = {{(MUL_W-H_W){h[H_W-1]}}, h};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rnd    = acc + RoundHalf;
    h_wide = rnd >>> FRAC_BITS;
    if (h_wide > HLimit) begin
      h_sat = H_W'(HLimit);
    end else if (h_wide < -HLimit) begin
      h_sat = H_W'(-HLimit);
    end else begin
      h_sat = h_wide[H_W-1:0];
    end
  end

  always_comb begin
    t   = -{{(T_W-H_W){h[H_W-1]}}, h} - {{(T_W-ROOT_W){1'b0}}, sq_root};
    hit = root_ok && (t > 0)
          && (t < $signed({{(T_W-DIST_W){1'b0}}, step_length}))
          && (t < $signed({{(T_W-DIST_W){1'b0}}, best_distance}));
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    emit_load  = 1'b0;
    case (state)
      S_IDLE:       if (accept) state_next = S_MUL_COS;
      S_MUL_COS:    state_next = S_MUL_SIN;
      S_MUL_SIN:    state_next = S_MUL_DXX;
      S_MUL_DXX:    state_next = S_MUL_DYY;
      S_MUL_DYY:    state_next = S_MUL_RS;
      S_MUL_RS:     state_next = S_MUL_HH;
      S_MUL_HH:     state_next = S_DISC;
      S_DISC:       state_next = S_SQRT_START;
      S_SQRT_START: begin
        if (acc > 0) begin
          sq_start   = 1'b1;
          state_next = S_SQRT_WAIT;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_SQRT_WAIT:  if (sq_done) state_next = S_EVAL;
      S_EVAL:       state_next = last_flag ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (!result_valid || !result_stall) begin
          emit_load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_RESET;
      dir_cos     <= COS_RESET;
      dir_sin     <= SIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STEP_LENGTH: step_length <= cfg_data[DIST_W-1:0];
        CFG_DIR_COS:     dir_cos     <= cfg_data[DIR_W-1:0];
        CFG_DIR_SIN:     dir_sin     <= cfg_data[DIR_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx        <= $signed({1'b0, pair.mover_x}) - $signed({1'b0, pair.target_x});
      dy        <= $signed({1'b0, pair.mover_y}) - $signed({1'b0, pair.target_y});
      rs        <= {1'b0, pair.mover_radius} + {1'b0, pair.target_radius};
      idx       <= pair.target_index & IdxMask;
      last_flag <= pair.last_pair;
    end
    prod <= mul_a * mul_b;
    case (state)
      S_MUL_SIN: acc <= prod;
      S_MUL_DXX: acc <= acc + prod;
      S_MUL_DYY: begin
        h   <= h_sat;
        acc <= prod;
      end
      S_MUL_RS:  acc <= acc + prod;
      S_MUL_HH:  acc <= acc - prod;
      S_DISC:    acc <= prod - acc;
      default:   ;
    endcase
    if (state == S_SQRT_START) begin
      root_ok <= (acc > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= '0;
      best_target   <= '0;
      any_hit       <= 1'b0;
    end else if (accept && pair.first_pair) begin
      best_distance <= step_length;
      best_target   <= '0;
      any_hit       <= 1'b0;
    end else if (state == S_EVAL && hit) begin
      best_distance <= t[DIST_W-1:0];
      best_target   <= idx;
      any_hit       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      result.hit_distance <= best_distance;
      result.hit_target   <= best_target;
      result.hit_found    <= any_hit;
    end
  end

endmodule

@@ test/tb_swept_circle_first_contact_unit.sv @@
// ----------------------------------------------------------------------------
// Swept circle first contact unit testbench
// Streams runs of circle pairs through the unit under several step lengths
// and directions, mirrors the running minimum in a local predictor and checks
// every reported result field by field, with random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
module tb_swept_circle_first_contact_unit;
  import scm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 110;
  localparam int     SETTLE      = 60;
  localparam int     IDLE_LIMIT  = 4000;
  localparam int     LONG_HOLD   = 400;
  localparam int     HOLD_AFTER  = 40;
  localparam int     RAD_MAX     = (1 << RAD_W) - 1;
  localparam longint POS_MAX     = (longint'(1) << POS_W) - 1;
  localparam longint H_LIMIT     = (longint'(1) << 30) - 1;
  localparam int     UNIT        = 1 << FRAC_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  pair_valid   = 1'b0;
  logic                  pair_stall;
  pair_t                 pair         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // register mirror and running minimum
  logic [DIST_W-1:0]       step_mirror = STEP_RESET;
  logic signed [DIR_W-1:0] cos_q       = COS_RESET;
  logic signed [DIR_W-1:0] sin_q       = SIN_RESET;
  logic [DIST_W-1:0]       best_dist   = '0;
  logic [IDX_W-1:0]        best_tgt    = '0;
  logic                    best_hit    = 1'b0;

  pair_t   pairs_to_send[$];
  result_t awaited_results[$];
  int      pairs_queued   = 0;
  int      pairs_accepted = 0;
  int      results_seen   = 0;
  int      mismatches     = 0;
  int      idle_cycles    = 0;
  logic    pair_taken     = 1'b0;

  int   burst_left = 0;
  int   gap_left   = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;
  int   mode_left  = 0;
  int   stall_mode = 0;

  swept_circle_first_contact_unit dut (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair         (pair),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned rem, root, probe;
    rem = v;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - root - probe;
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // update the running minimum with one pair; 1 when the pair closes a run
  function automatic bit advance_contact(input pair_t p, output result_t r);
    longint dx, dy, h, rs, c, disc, t;
    if (p.first_pair) begin
      best_dist = step_mirror;
      best_tgt = '0;
      best_hit = 1'b0;
    end
    dx = longint'(p.mover_x) - longint'(p.target_x);
    dy = longint'(p.mover_y) - longint'(p.target_y);
    h = (longint'(cos_q) * dx + longint'(sin_q) * dy + (UNIT / 2)) >>> FRAC_BITS_DEF;
    if (h > H_LIMIT) h = H_LIMIT;
    if (h < -H_LIMIT) h = -H_LIMIT;
    rs = longint'(p.mover_radius) + longint'(p.target_radius);
    c = dx * dx + dy * dy - rs * rs;
    disc = h * h - c;
    if (disc > 0) begin
      t = -h - longint'(floor_sqrt(disc));
      if (t > 0 && t < longint'(step_mirror) && t < longint'(best_dist)) begin
        best_dist = t[DIST_W-1:0];
        best_tgt = p.target_index;
        best_hit = 1'b1;
      end
    end
    r.hit_distance = best_dist;
    r.hit_target = best_tgt;
    r.hit_found = best_hit;
    return p.last_pair;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v < 0) return 0;
    if (v > POS_MAX) return POS_MAX;
    return v;
  endfunction

  // place the target along and across the current direction from a random mover
  function automatic pair_t pair_at(input longint along, input longint perp,
                                    input int unsigned mr, input int unsigned tr,
                                    input int unsigned idx, input bit first,
                                    input bit last);
    pair_t p;
    longint mx, my, tx, ty;
    mx = longint'($urandom_range(1 << 24, 3 << 24));
    my = longint'($urandom_range(1 << 24, 3 << 24));
    tx = clamp_pos(mx + ((along * longint'(cos_q) - perp * longint'(sin_q)) >>> FRAC_BITS_DEF));
    ty = clamp_pos(my + ((along * longint'(sin_q) + perp * longint'(cos_q)) >>> FRAC_BITS_DEF));
    p.mover_x = mx[POS_W-1:0];
    p.mover_y = my[POS_W-1:0];
    p.mover_radius = mr[RAD_W-1:0];
    p.target_x = tx[POS_W-1:0];
    p.target_y = ty[POS_W-1:0];
    p.target_radius = tr[RAD_W-1:0];
    p.target_index = idx[IDX_W-1:0];
    p.first_pair = first;
    p.last_pair = last;
    return p;
  endfunction

  function automatic pair_t random_pair(input bit first, input bit last);
    int unsigned mr, tr, span;
    longint along, perp;
    mr = ($urandom_range(0, 15) == 0) ? $urandom_range(0, RAD_MAX) : $urandom_range(0, 2 * UNIT);
    tr = ($urandom_range(0, 15) == 0) ? $urandom_range(0, RAD_MAX) : $urandom_range(0, 2 * UNIT);
    along = longint'($urandom_range(0, step_mirror + 2 * (mr + tr) + UNIT));
    if ($urandom_range(0, 7) == 0) along = -along;
    span = mr + tr + (mr + tr) / 4 + 1;
    perp = longint'($urandom_range(0, 2 * span)) - longint'(span);
    return pair_at(along, perp, mr, tr, $urandom_range(0, 65535), first, last);
  endfunction

  task automatic queue_pair(input pair_t p);
    pairs_to_send = {pairs_to_send, p};
    pairs_queued++;
  endtask

  task automatic queue_random(input int n);
    int made, len;
    bit skip_first;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_pair(pair_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()}));
        made++;
      end else begin
        len = $urandom_range(1, 8);
        skip_first = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
          queue_pair(random_pair(k == 0 && !skip_first, k == len - 1));
          made++;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_STEP_LENGTH: step_mirror = val;
      CFG_DIR_COS:     cos_q = val[DIR_W-1:0];
      CFG_DIR_SIN:     sin_q = val[DIR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    while (pairs_accepted != pairs_queued || awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // sender: bursts of items separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (pair_valid && !pair_taken) begin
      // hold the stalled item
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      pair_valid <= 1'b0;
    end else if (pairs_to_send.size() > 0) begin
      pair <= pairs_to_send.pop_front();
      pair_valid <= 1'b1;
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      end
    end else begin
      pair_valid <= 1'b0;
    end
  end

  // receiver: stall pattern with one long hold once results are flowing
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(10, 80);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // check results, predict accepted items, watch for a hang
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pair_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          note_mismatch("unexpected result, hit_distance", -1, result.hit_distance);
        end else begin
          want = awaited_results.pop_front();
          if (result.hit_distance !== want.hit_distance)
            note_mismatch("hit_distance", want.hit_distance, result.hit_distance);
          if (result.hit_target !== want.hit_target)
            note_mismatch("hit_target", want.hit_target, result.hit_target);
          if (result.hit_found !== want.hit_found)
            note_mismatch("hit_found", want.hit_found, result.hit_found);
        end
      end
      if (pair_valid && !pair_stall) begin
        pairs_accepted <= pairs_accepted + 1;
        if (advance_contact(pair, want)) awaited_results = {awaited_results, want};
      end
      pair_taken <= pair_valid && !pair_stall;
      if ((pair_valid && !pair_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    pair_t p;
    int unsigned phase_step[PHASES];
    int          phase_cos[PHASES];
    int          phase_sin[PHASES];
    int unsigned r;
    phase_step = '{262144, 16777215, 0, 524288, 196608, 1, 327680, 0};
    phase_cos  = '{65536, 0, -65536, 46341, -46341, 0, 131071, 0};
    phase_sin  = '{0, 65536, 0, 46341, -46341, -65536, -131072, 0};
    phase_step[PHASES-1] = $urandom_range(0, 24'hFFFFFF);
    phase_cos[PHASES-1] = $urandom();
    phase_sin[PHASES-1] = $urandom();
    r = UNIT / 4;

    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // reset settings: step of one unit along +x, radii summing to half a unit
    queue_pair(pair_at(50000, 0, r, r, 7, 1'b0, 1'b1));
    queue_pair(pair_at(50000, 0, r, r, 9, 1'b1, 1'b1));
    queue_pair(pair_at(2 * r, 0, r, r, 10, 1'b1, 1'b1));
    queue_pair(pair_at(UNIT + 2 * r, 0, r, r, 11, 1'b1, 1'b1));
    queue_pair(pair_at(UNIT + 2 * r - 1, 0, r, r, 16'hFFFF, 1'b1, 1'b1));
    queue_pair(pair_at(50000, 2 * r, r, r, 12, 1'b1, 1'b1));
    queue_pair(pair_at(50000, 40000, r, r, 13, 1'b1, 1'b1));
    queue_pair(pair_at(-50000, 0, r, r, 14, 1'b1, 1'b1));
    queue_pair(pair_at(10000, 0, r, r, 15, 1'b1, 1'b1));
    queue_pair(pair_at(50000, 0, r, r, 3, 1'b1, 1'b0));
    queue_pair(pair_at(50000, 0, r, r, 4, 1'b0, 1'b0));
    queue_pair(pair_at(60000, 0, r, r, 6, 1'b0, 1'b1));
    queue_pair(pair_at(45000, 0, r, r, 8, 1'b0, 1'b1));
    queue_pair(pair_at(0, 0, 0, 0, 0, 1'b1, 1'b1));
    p = '0;
    queue_pair(p);
    p = '1;
    queue_pair(p);
    p = '0;
    p.target_x = '1;
    p.target_y = '1;
    p.mover_radius = '1;
    p.target_radius = '1;
    p.target_index = '1;
    p.first_pair = 1'b1;
    p.last_pair = 1'b1;
    queue_pair(p);
    p.mover_x = '1;
    p.mover_y = '1;
    p.target_x = '0;
    p.target_y = '0;
    queue_pair(p);
    wait_quiet();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_STEP_LENGTH, CFG_DATA_W'(phase_step[ph]));
      write_reg(CFG_DIR_COS, {6'($urandom()), DIR_W'(phase_cos[ph])});
      write_reg(CFG_DIR_SIN, {6'($urandom()), DIR_W'(phase_sin[ph])});
      if (ph == PHASES - 1) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
      @(negedge clk) cfg_write <= 1'b0;
      @(posedge clk);
      queue_random(PHASE_ITEMS);
      wait_quiet();
    end

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
